// ===== sv/breakpoint_address_table_core_macros.svh =====
// Assertion macros used by the breakpoint address table core.
`ifndef BREAKPOINT_ADDRESS_TABLE_CORE_MACROS_SVH
`define BREAKPOINT_ADDRESS_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that a consequent holds in the same cycle as its antecedent.
`define BAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Check that a consequent holds in the cycle after its antecedent.
`define BAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define BAT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/bat_pkg.sv =====
// Types and constants shared by the breakpoint address table modules.
package bat_pkg;

    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int RES_W    = STATUS_W + SLOT_W + 1;
    localparam int RES_BYTES_W = ((RES_W + 7) / 8) * 8;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_SET    = 2'd0;
    localparam t_mode MODE_CLEAR  = 2'd1;
    localparam t_mode MODE_LOOKUP = 2'd2;

    localparam t_status STATUS_DONE      = 2'd0;
    localparam t_status STATUS_FULL      = 2'd1;
    localparam t_status STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic found;
        logic have_free;
    } t_scan_flags;

endpackage

// ===== sv/bat_match.sv =====
// Parallel compare of all slots and lowest-index match and free-slot encoders.
module bat_match #(
    parameter int SLOTS = 16,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS-1:0]                      i_valid,
    input  logic [SLOTS-1:0][bat_pkg::ADDR_W-1:0] i_slot_addr,
    input  logic [bat_pkg::ADDR_W-1:0]            i_addr,
    output bat_pkg::t_scan_flags                  o_flags,
    output logic [IDX_W-1:0]                      o_match_idx,
    output logic [IDX_W-1:0]                      o_free_idx
);
    import bat_pkg::*;

    logic [SLOTS-1:0] w_eq;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_eq[i] = i_valid[i] && (i_slot_addr[i] == i_addr);
        end
    end

    // Walk from the top so the lowest hit is the one that sticks.
    always_comb begin
        o_match_idx = '0;
        o_free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (w_eq[i]) begin
                o_match_idx = IDX_W'(i);
            end
            if (!i_valid[i]) begin
                o_free_idx = IDX_W'(i);
            end
        end
        o_flags.found     = |w_eq;
        o_flags.have_free = ~&i_valid;
    end

endmodule

// ===== sv/breakpoint_address_table_core.sv =====
// Top level of the breakpoint address table: request register, slot table, result register.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the mode (set, clear,
//   look up; the unused code behaves as look up) and tdata the 32-bit address.
//   Each request yields exactly one result beat on m_axis: status, slot, hit.
//   A beat is taken into the request register, where all SLOTS entries are
//   compared with it in parallel; when the request advances, the result
//   register and the slot table update at the same edge. One request is
//   accepted every cycle while the receiver does not stall. The rate is set
//   by the combinational compare across all slots, which lets each request
//   see the table left by the one before it.
//   When the receiver stalls, the result register holds; the request register
//   still takes one more beat, then s_axis_tready drops until the result moves.
//   Reset (synchronous, active low) invalidates every slot at once and empties
//   both registers; slot addresses are not cleared, since a slot is only read
//   while valid.
//   Slot indices wider than four bits are reported by their low four bits.
module breakpoint_address_table_core #(
    parameter int SLOTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bat_pkg::ADDR_W-1:0]         s_axis_tdata,  // [31:0] address
    input  logic [bat_pkg::MODE_W-1:0]         s_axis_tuser,  // [1:0] mode
    // Result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bat_pkg::RES_BYTES_W-1:0]    m_axis_tdata   // [1:0] status, [5:2] slot,
                                                              // [6] hit, rest zero
);
    import bat_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Request register
    logic              r_in_valid;
    t_mode             r_in_mode;
    logic [ADDR_W-1:0] r_in_addr;

    // Slot table
    logic [SLOTS-1:0]             r_valid;
    logic [SLOTS-1:0]             n_valid;
    logic [SLOTS-1:0][ADDR_W-1:0] r_slot_addr;

    // Result register
    logic              r_out_valid;
    t_status           r_status;
    logic [SLOT_W-1:0] r_slot;
    logic              r_hit;
    t_status           n_status;
    logic [SLOT_W-1:0] n_slot;
    logic              n_hit;

    t_scan_flags       w_flags;
    logic [IDX_W-1:0]  w_match_idx;
    logic [IDX_W-1:0]  w_free_idx;
    logic              w_fire;
    logic              w_is_set;
    logic              w_is_clear;
    logic              w_claim;
    logic              w_drop;
    logic [IDX_W+SLOT_W-1:0] w_match_ext;
    logic [IDX_W+SLOT_W-1:0] w_free_ext;

    // Advance the request into the result register when that is free or draining.
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    assign w_is_set   = (r_in_mode == MODE_SET);
    assign w_is_clear = (r_in_mode == MODE_CLEAR);
    assign w_claim    = w_fire && w_is_set && !w_flags.found && w_flags.have_free;
    assign w_drop     = w_fire && w_is_clear && w_flags.found;

    bat_match #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_match (
        .i_valid     (r_valid),
        .i_slot_addr (r_slot_addr),
        .i_addr      (r_in_addr),
        .o_flags     (w_flags),
        .o_match_idx (w_match_idx),
        .o_free_idx  (w_free_idx)
    );

    // Zero-extend first, then keep the low four bits, so any SLOTS fits.
    assign w_match_ext = {{SLOT_W{1'b0}}, w_match_idx};
    assign w_free_ext  = {{SLOT_W{1'b0}}, w_free_idx};

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_valid[i] = r_valid[i];
            if (w_claim && (w_free_idx == IDX_W'(i))) begin
                n_valid[i] = 1'b1;
            end
            if (w_drop && (w_match_idx == IDX_W'(i))) begin
                n_valid[i] = 1'b0;
            end
        end
    end

    always_comb begin
        n_status = STATUS_NOT_FOUND;
        n_slot   = '0;
        n_hit    = 1'b0;
        if (w_flags.found) begin
            n_status = STATUS_DONE;
            n_slot   = w_match_ext[SLOT_W-1:0];
            n_hit    = 1'b1;
        end else if (w_is_set) begin
            if (w_flags.have_free) begin
                n_status = STATUS_DONE;
                n_slot   = w_free_ext[SLOT_W-1:0];
            end else begin
                n_status = STATUS_FULL;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_valid <= n_valid;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_addr <= s_axis_tdata;
        end
        if (w_fire) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_hit    <= n_hit;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (w_claim && (w_free_idx == IDX_W'(i))) begin
                r_slot_addr[i] <= r_in_addr;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(RES_BYTES_W - RES_W){1'b0}}, r_hit, r_slot, r_status};

`include "breakpoint_address_table_core_macros.svh"

    // Back-pressure only when both registers are full and the receiver stalls.
    `BAT_ASSERT_NOW(a_ready_only_when_blocked, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready)
    // A pending full report means every slot is taken.
    `BAT_ASSERT_NOW(a_full_means_all_valid, i_clk, i_rst_n, r_out_valid && (r_status == STATUS_FULL), &r_valid)
    // A clear that hits leaves its slot invalid.
    `BAT_ASSERT_NEXT(a_clear_drops_slot, i_clk, i_rst_n, w_drop, !r_valid[$past(w_match_idx)])

endmodule
